@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/mprld_pkg.sv @@
// ----------------------------------------------------------------------------
// Mask payload run-length decoder package
// Beat, command and back-end state types, status codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mprld_pkg;

   localparam int HEADER_BYTES   = 5;
   localparam int HDR_CNT_BITS   = 3;
   localparam int INT_WIDTH_BITS = 7;
   localparam int BODY_CNT_BITS  = 30;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [BODY_CNT_BITS-1:0] BODY_COUNT_MAX = '1;
   localparam logic [5:0]               WIDTH_FIELD_MASK = 6'h3F;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_SHORT_HEADER  = 2'd1,
      STATUS_SIZE_MISMATCH = 2'd2,
      STATUS_TRUNCATED     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HEADER = 2'd0,
      CMD_BODY   = 2'd1,
      CMD_SHORT  = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_SCAN  = 2'd1,
      BK_RUN   = 2'd2,
      BK_ERROR = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic        bit_value;
      logic [31:0] run_length;
      logic        last_run;
      status_type  status;
   } rsp_beat_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [7:0]                data_byte;
      logic                      last_byte;
      logic                      is_bitmask;
      logic                      start_value;
      logic [INT_WIDTH_BITS-1:0] int_width;
      logic [31:0]               total_bits;
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/mask_payload_run_length_decoder.sv @@
// A beat enters the command queue at its accepting edge; the back end fetches a body byte
// when idle and walks it bit by bit on the single-bit run engine, pausing while the output
// is stalled and registering each run as its integer closes. The final run-length byte is
// first scanned to check that it ends the mask, then restored and walked to emit its runs.
// Reset is synchronous and clears the control state; no memory needs a clearing pass.
// ----------------------------------------------------------------------------
// Mask payload run-length decoder
// Front end parses the header, a short queue decouples it from the run engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mask_payload_run_length_decoder #(
   parameter int MAX_INT_BITS = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  mprld_pkg::req_beat_type req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mprld_pkg::rsp_beat_type rsp_data
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_not_empty;
   mprld_pkg::cmd_type q_in_data;
   mprld_pkg::cmd_type q_out_data;

   mprld_front #(
      .MAX_INT_BITS (MAX_INT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_push  (q_push),
      .cmd_data  (q_in_data),
      .cmd_full  (q_full)
   );

   mprld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .not_empty (q_not_empty)
   );

   mprld_back #(
      .MAX_INT_BITS (MAX_INT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd_data  (q_out_data),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An error beat is always a closing beat with an empty run.
   `ASSERT_IMPLIES(a_err_beat_form, clock, reset, rsp_valid && (rsp_data.status != mprld_pkg::STATUS_OK), rsp_data.last_run && (rsp_data.run_length == 32'd0) && !rsp_data.bit_value, "error beat is malformed")
   `ASSERT_IMPLIES(a_ok_run_nonempty, clock, reset, rsp_valid && (rsp_data.status == mprld_pkg::STATUS_OK), rsp_data.run_length != 32'd0, "good run has zero length")
   `ASSERT_IMPLIES(a_no_beat_after_reset, clock, reset, $past(reset), !rsp_valid && !q_not_empty, "output or queue not empty after reset")

endmodule

`default_nettype wire

@@ hdl/mprld_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts payload beats, parses the header and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mprld_front #(
   parameter int MAX_INT_BITS = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  mprld_pkg::req_beat_type req_data,
   output logic                    cmd_push,
   output mprld_pkg::cmd_type      cmd_data,
   input  wire                     cmd_full
);

   logic [mprld_pkg::HDR_CNT_BITS-1:0]   hdr_count_ff, hdr_count_in;
   logic                                 in_body_ff, in_body_in;
   logic                                 format_ff, format_in;
   logic                                 start_ff, start_in;
   logic [mprld_pkg::INT_WIDTH_BITS-1:0] width_ff, width_in;
   logic [31:0]                          total_ff, total_in;
   logic [mprld_pkg::INT_WIDTH_BITS-1:0] width_raw;
   logic                                 accept;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;
   assign width_raw = {1'b0, req_data.data_byte[5:0] & mprld_pkg::WIDTH_FIELD_MASK} +
                      mprld_pkg::INT_WIDTH_BITS'(1);

   always_comb begin
      hdr_count_in        = hdr_count_ff;
      in_body_in          = in_body_ff;
      format_in           = format_ff;
      start_in            = start_ff;
      width_in            = width_ff;
      total_in            = total_ff;
      cmd_push            = 1'b0;
      cmd_data.kind       = mprld_pkg::CMD_BODY;
      cmd_data.data_byte  = req_data.data_byte;
      cmd_data.last_byte  = req_data.last_byte;
      if (accept) begin
         if (!in_body_ff) begin
            if (hdr_count_ff == '0) begin
               format_in = req_data.data_byte[7];
               if (req_data.data_byte[7]) begin
                  width_in = mprld_pkg::INT_WIDTH_BITS'(1);
                  start_in = 1'b0;
               end else begin
                  width_in = (width_raw > mprld_pkg::INT_WIDTH_BITS'(MAX_INT_BITS)) ?
                             mprld_pkg::INT_WIDTH_BITS'(MAX_INT_BITS) : width_raw;
                  start_in = req_data.data_byte[6];
               end
               total_in = '0;
            end else begin
               total_in = {total_ff[23:0], req_data.data_byte};
            end
            hdr_count_in = hdr_count_ff + mprld_pkg::HDR_CNT_BITS'(1);
            if (hdr_count_in == mprld_pkg::HDR_CNT_BITS'(mprld_pkg::HEADER_BYTES)) begin
               cmd_push      = 1'b1;
               cmd_data.kind = mprld_pkg::CMD_HEADER;
               in_body_in    = 1'b1;
            end else if (req_data.last_byte) begin
               cmd_push      = 1'b1;
               cmd_data.kind = mprld_pkg::CMD_SHORT;
            end
         end else begin
            cmd_push      = 1'b1;
            cmd_data.kind = mprld_pkg::CMD_BODY;
         end
         if (req_data.last_byte) begin
            hdr_count_in = '0;
            in_body_in   = 1'b0;
         end
      end
      cmd_data.is_bitmask  = format_in;
      cmd_data.start_value = start_in;
      cmd_data.int_width   = width_in;
      cmd_data.total_bits  = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff <= '0;
         in_body_ff   <= 1'b0;
      end else begin
         hdr_count_ff <= hdr_count_in;
         in_body_ff   <= in_body_in;
      end
   end

   always_ff @(posedge clock) begin
      format_ff <= format_in;
      start_ff  <= start_in;
      width_ff  <= width_in;
      total_ff  <= total_in;
   end

endmodule

`default_nettype wire

@@ hdl/mprld_queue.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mprld_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  mprld_pkg::cmd_type push_data,
   output logic               full,
   input  wire                pop,
   output mprld_pkg::cmd_type pop_data,
   output logic               not_empty
);

   localparam int PTR_BITS = (mprld_pkg::QUEUE_DEPTH > 1) ? $clog2(mprld_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(mprld_pkg::QUEUE_DEPTH + 1);

   mprld_pkg::cmd_type  mem_ff [mprld_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(mprld_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(mprld_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(mprld_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/mprld_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Walks body bytes one bit per cycle unless stalled; forms runs, drives rsp.
// ----------------------------------------------------------------------------
`default_nettype none

module mprld_back #(
   parameter int MAX_INT_BITS = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     cmd_valid,
   input  mprld_pkg::cmd_type      cmd_data,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mprld_pkg::rsp_beat_type rsp_data
);

   localparam int AW = MAX_INT_BITS;
   localparam int CW = (MAX_INT_BITS > 32) ? MAX_INT_BITS : 33;
   localparam int WB = mprld_pkg::INT_WIDTH_BITS;
   localparam int BB = mprld_pkg::BODY_CNT_BITS;

   mprld_pkg::back_state_type state_ff, state_in;
   mprld_pkg::status_type     err_ff;
   mprld_pkg::rsp_beat_type   rsp_data_ff;
   logic                      rsp_valid_ff;

   logic [7:0]    byte_ff;
   logic [2:0]    bit_idx_ff;
   logic          is_bitmask_ff;
   logic [WB-1:0] width_ff;
   logic [31:0]   total_ff;
   logic [31:0]   remaining_ff, remaining_save_ff;
   logic [AW-1:0] acc_ff, acc_save_ff;
   logic [WB-1:0] acc_cnt_ff, acc_cnt_save_ff;
   logic          current_ff, current_save_ff;
   logic          done_ff;
   logic [BB-1:0] body_cnt_ff;

   logic          out_free;
   logic          bit_sel;
   logic [AW-1:0] acc_shift;
   logic [WB-1:0] cnt_inc;
   logic          fire;
   logic [CW-1:0] acc_ext;
   logic          covers;
   logic [31:0]   run_len;
   logic          run_done;
   logic          last_step;
   logic [BB-1:0] body_cnt_inc;
   logic [BB-1:0] expected;
   logic          bm_err;

   logic          step_en;
   logic          emit_run;
   logic          emit_err;
   logic          restore;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bit_sel   = is_bitmask_ff ? byte_ff[bit_idx_ff] : byte_ff[3'd7 - bit_idx_ff];
   assign acc_shift = {acc_ff[AW-2:0], bit_sel};
   assign cnt_inc   = acc_cnt_ff + WB'(1);
   assign fire      = is_bitmask_ff || (cnt_inc >= width_ff);
   assign acc_ext   = CW'(acc_shift);
   assign covers    = (acc_ext >= CW'(remaining_ff));
   assign run_len   = is_bitmask_ff ? 32'd1 :
                      (covers ? remaining_ff : acc_ext[31:0] + 32'd1);
   assign run_done  = is_bitmask_ff ? (remaining_ff == 32'd1) : (run_len == remaining_ff);
   assign last_step = (fire && run_done) || (bit_idx_ff == 3'd7);

   assign body_cnt_inc = (body_cnt_ff == mprld_pkg::BODY_COUNT_MAX) ? body_cnt_ff :
                         body_cnt_ff + BB'(1);
   assign expected     = {1'b0, total_ff[31:3]} + BB'(|total_ff[2:0]);
   assign bm_err       = cmd_data.last_byte && is_bitmask_ff && (body_cnt_inc != expected);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mprld_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.kind)
                  mprld_pkg::CMD_HEADER: begin
                     state_in = (cmd_data.last_byte && (cmd_data.total_bits != '0)) ?
                                mprld_pkg::BK_ERROR : mprld_pkg::BK_IDLE;
                  end
                  mprld_pkg::CMD_SHORT: begin
                     state_in = mprld_pkg::BK_ERROR;
                  end
                  mprld_pkg::CMD_BODY: begin
                     priority if (bm_err) begin
                        state_in = mprld_pkg::BK_ERROR;
                     end else if (done_ff) begin
                        state_in = mprld_pkg::BK_IDLE;
                     end else if (!is_bitmask_ff && cmd_data.last_byte) begin
                        state_in = mprld_pkg::BK_SCAN;
                     end else begin
                        state_in = mprld_pkg::BK_RUN;
                     end
                  end
                  default: begin
                     state_in = mprld_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         mprld_pkg::BK_SCAN: begin
            if (last_step) begin
               state_in = (fire && run_done) ? mprld_pkg::BK_RUN : mprld_pkg::BK_ERROR;
            end
         end
         mprld_pkg::BK_RUN: begin
            if (out_free && last_step) begin
               state_in = mprld_pkg::BK_IDLE;
            end
         end
         mprld_pkg::BK_ERROR: begin
            if (out_free) begin
               state_in = mprld_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mprld_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop  = 1'b0;
      step_en  = 1'b0;
      emit_run = 1'b0;
      emit_err = 1'b0;
      restore  = 1'b0;
      unique case (state_ff)
         mprld_pkg::BK_IDLE: begin
            cmd_pop = cmd_valid;
         end
         mprld_pkg::BK_SCAN: begin
            step_en = 1'b1;
            restore = last_step && fire && run_done;
         end
         mprld_pkg::BK_RUN: begin
            step_en  = out_free;
            emit_run = out_free && fire;
         end
         mprld_pkg::BK_ERROR: begin
            emit_err = out_free;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mprld_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_run || emit_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_run) begin
         rsp_data_ff.bit_value  <= is_bitmask_ff ? bit_sel : current_ff;
         rsp_data_ff.run_length <= run_len;
         rsp_data_ff.last_run   <= run_done;
         rsp_data_ff.status     <= mprld_pkg::STATUS_OK;
      end else if (emit_err) begin
         rsp_data_ff.bit_value  <= 1'b0;
         rsp_data_ff.run_length <= '0;
         rsp_data_ff.last_run   <= 1'b1;
         rsp_data_ff.status     <= err_ff;
      end

      if (cmd_pop) begin
         byte_ff    <= cmd_data.data_byte;
         bit_idx_ff <= '0;
         unique case (cmd_data.kind)
            mprld_pkg::CMD_HEADER: begin
               is_bitmask_ff <= cmd_data.is_bitmask;
               width_ff      <= cmd_data.int_width;
               total_ff      <= cmd_data.total_bits;
               remaining_ff  <= cmd_data.total_bits;
               current_ff    <= cmd_data.start_value;
               acc_ff        <= '0;
               acc_cnt_ff    <= '0;
               body_cnt_ff   <= '0;
               done_ff       <= (cmd_data.total_bits == '0);
               err_ff        <= cmd_data.is_bitmask ? mprld_pkg::STATUS_SIZE_MISMATCH :
                                mprld_pkg::STATUS_TRUNCATED;
            end
            mprld_pkg::CMD_SHORT: begin
               err_ff <= mprld_pkg::STATUS_SHORT_HEADER;
            end
            mprld_pkg::CMD_BODY: begin
               if (is_bitmask_ff) begin
                  body_cnt_ff <= body_cnt_inc;
               end
               err_ff            <= mprld_pkg::STATUS_SIZE_MISMATCH;
               acc_save_ff       <= acc_ff;
               acc_cnt_save_ff   <= acc_cnt_ff;
               remaining_save_ff <= remaining_ff;
               current_save_ff   <= current_ff;
            end
            default: begin
               err_ff <= err_ff;
            end
         endcase
      end else if (restore) begin
         acc_ff       <= acc_save_ff;
         acc_cnt_ff   <= acc_cnt_save_ff;
         remaining_ff <= remaining_save_ff;
         current_ff   <= current_save_ff;
         done_ff      <= 1'b0;
         bit_idx_ff   <= '0;
      end else if (step_en) begin
         bit_idx_ff <= bit_idx_ff + 3'd1;
         if (fire) begin
            remaining_ff <= remaining_ff - run_len;
            done_ff      <= run_done;
            current_ff   <= ~current_ff;
            acc_ff       <= '0;
            acc_cnt_ff   <= '0;
         end else begin
            acc_ff     <= acc_shift;
            acc_cnt_ff <= cnt_inc;
         end
         if ((state_ff == mprld_pkg::BK_SCAN) && last_step && !(fire && run_done)) begin
            err_ff <= mprld_pkg::STATUS_TRUNCATED;
         end
      end
   end

endmodule

`default_nettype wire

@@ dv/tb_mask_payload_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// Mask payload run-length decoder testbench
// Feeds header and body bytes through the valid/stall request channel and
// compares every run that comes back against a behavioural decoder kept in
// step with the accepted beats, or fixed results from a short directed table
// that opens the run. Random payloads follow, mostly well formed, under random
// gaps, receiver back-pressure, one long hold-off and pauses for all runs.
// ----------------------------------------------------------------------------
module tb_mask_payload_run_length_decoder;

   import mprld_pkg::*;

   localparam int WIDEST_INT     = 64;
   localparam int RANDOM_BEATS   = 304;
   localparam int DRAIN_CYCLES   = 24;
   localparam int HOLD_CYCLES    = 150;
   localparam int OPENING_COUNT  = 26;

   typedef enum logic [1:0] {
      PARSE_HEADER = 2'd0,
      PARSE_BODY   = 2'd1,
      PARSE_DONE   = 2'd2
   } parse_phase_type;

   typedef enum logic [1:0] {
      STALL_NONE     = 2'd0,
      STALL_LIGHT    = 2'd1,
      STALL_HEAVY    = 2'd2,
      STALL_PERIODIC = 2'd3
   } stall_style_type;

   typedef struct packed {
      logic [7:0]   data_byte;
      logic         last_byte;
      logic         fixed;
      logic         one_run;
      rsp_beat_type fixed_rsp;
   } opening_row_type;

   localparam rsp_beat_type NO_RSP = '0;
   localparam rsp_beat_type SHORT_HEADER_RSP = {1'b0, 32'd0, 1'b1, STATUS_SHORT_HEADER};
   localparam rsp_beat_type TRUNCATED_RSP = {1'b0, 32'd0, 1'b1, STATUS_TRUNCATED};
   localparam rsp_beat_type SIZE_MISMATCH_RSP = {1'b0, 32'd0, 1'b1, STATUS_SIZE_MISMATCH};

   // Short header; run-length, width 1, start 1, twelve bits; widest integer
   // with the longest mask cut off; zero mask length; bitmask with a trailing
   // byte.
   localparam opening_row_type OPENING_ROWS [OPENING_COUNT] = '{
      {8'h00, 1'b1, 1'b1, 1'b1, SHORT_HEADER_RSP},
      {8'h40, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h0C, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'hA5, 1'b1, 1'b0, 1'b0, NO_RSP},
      {8'h3F, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b1, 1'b1, 1'b1, TRUNCATED_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b1, 1'b1, 1'b0, NO_RSP},
      {8'hFF, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h0A, 1'b0, 1'b1, 1'b0, NO_RSP},
      {8'h5A, 1'b0, 1'b0, 1'b0, NO_RSP},
      {8'h03, 1'b0, 1'b0, 1'b0, NO_RSP},
      {8'hFF, 1'b1, 1'b1, 1'b1, SIZE_MISMATCH_RSP}
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_beat_type rsp_data;

   parse_phase_type          parse;
   int                       hdr_seen;
   logic                     is_bitmask;
   int                       word_width;
   logic                     first_value;
   logic [31:0]              mask_len;
   logic [31:0]              bits_out;
   logic [63:0]              shift_acc;
   int                       shift_cnt;
   logic                     run_value;
   logic [BODY_CNT_BITS-1:0] body_bytes;

   rsp_beat_type byte_runs [$];
   bit           byte_ignored;
   rsp_beat_type expected_runs [$];
   rsp_beat_type want_run;
   logic [7:0]   payload_bytes [$];

   int unsigned mismatches = 0;
   int unsigned runs_checked = 0;
   int unsigned error_reports = 0;
   int unsigned useful_beats = 0;
   int unsigned payloads = 0;
   int unsigned burst_left = 0;
   bit          steady = 1'b0;
   int unsigned hold_asks = 0;
   int unsigned holds_done = 0;

   mask_payload_run_length_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic void add_run(logic v, logic [31:0] len, logic fin, status_type st);
      rsp_beat_type run;
      run.bit_value  = v;
      run.run_length = len;
      run.last_run   = fin;
      run.status     = st;
      byte_runs.push_back(run);
   endfunction

   function automatic void decode_byte(req_beat_type beat);
      logic [7:0]  b;
      logic        fin;
      status_type  err;
      logic [31:0] remaining;
      logic [31:0] len;
      logic [31:0] want_bytes;
      b   = beat.data_byte;
      fin = beat.last_byte;
      err = STATUS_OK;
      byte_runs.delete();
      byte_ignored = 1'b0;
      if (parse == PARSE_HEADER) begin
         if (hdr_seen == 0) begin
            is_bitmask = b[7];
            if (is_bitmask) begin
               word_width  = 1;
               first_value = 1'b0;
            end else begin
               word_width = int'(b[5:0]) + 1;
               if (word_width > WIDEST_INT) word_width = WIDEST_INT;
               first_value = b[6];
            end
            mask_len = '0;
         end else begin
            mask_len = {mask_len[23:0], b};
         end
         hdr_seen++;
         if (hdr_seen >= HEADER_BYTES) begin
            parse      = (mask_len == 0) ? PARSE_DONE : PARSE_BODY;
            run_value  = first_value;
            bits_out   = '0;
            shift_acc  = '0;
            shift_cnt  = 0;
            body_bytes = '0;
         end else if (fin) begin
            err = STATUS_SHORT_HEADER;
         end
      end else begin
         byte_ignored = !is_bitmask && parse == PARSE_DONE && !fin;
         if (is_bitmask && body_bytes != BODY_COUNT_MAX) body_bytes++;
         if (parse == PARSE_BODY) begin
            if (is_bitmask) begin
               for (int i = 0; i < 8 && parse == PARSE_BODY; i++) begin
                  bits_out++;
                  if (bits_out >= mask_len) parse = PARSE_DONE;
                  add_run(b[i], 32'd1, parse == PARSE_DONE, STATUS_OK);
               end
            end else begin
               for (int i = 7; i >= 0 && parse == PARSE_BODY; i--) begin
                  shift_acc = {shift_acc[62:0], b[i]};
                  shift_cnt++;
                  if (shift_cnt >= word_width) begin
                     remaining = mask_len - bits_out;
                     len = (shift_acc >= {32'd0, remaining}) ? remaining
                                                              : shift_acc[31:0] + 32'd1;
                     bits_out += len;
                     if (bits_out >= mask_len) parse = PARSE_DONE;
                     add_run(run_value, len, parse == PARSE_DONE, STATUS_OK);
                     run_value = ~run_value;
                     shift_acc = '0;
                     shift_cnt = 0;
                  end
               end
            end
         end
      end
      if (fin && err == STATUS_OK && parse != PARSE_HEADER) begin
         if (is_bitmask) begin
            want_bytes = (mask_len >> 3) + {31'd0, mask_len[2:0] != 3'd0};
            if (32'(body_bytes) != want_bytes) err = STATUS_SIZE_MISMATCH;
         end else if (bits_out < mask_len) begin
            err = STATUS_TRUNCATED;
         end
      end
      if (fin) begin
         parse      = PARSE_HEADER;
         hdr_seen   = 0;
         mask_len   = '0;
         bits_out   = '0;
         shift_acc  = '0;
         shift_cnt  = 0;
         body_bytes = '0;
      end
      if (err != STATUS_OK) begin
         byte_runs.delete();
         add_run(1'b0, 32'd0, 1'b1, err);
      end
   endfunction

   function automatic void build_payload();
      int          shape;
      int          w;
      longint      nbytes;
      logic [31:0] len;
      logic [63:0] v;
      logic [63:0] lim;
      longint      covered;
      logic [7:0]  by;
      bit          bitq [$];
      payload_bytes.delete();
      shape = $urandom_range(0, 19);
      if (shape < 5) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
         if ($urandom_range(0, 15) == 0) len = $urandom;
         nbytes = (longint'(len) + 7) >> 3;
         if (nbytes > 12) nbytes = $urandom_range(0, 3);
         case ($urandom_range(0, 5))
            0: nbytes++;
            1: if (nbytes > 0) nbytes--;
            default: ;
         endcase
         payload_bytes.push_back({1'b1, 7'($urandom)});
         for (int k = 3; k >= 0; k--) payload_bytes.push_back(len[8*k +: 8]);
         for (longint k = 0; k < nbytes; k++) payload_bytes.push_back(8'($urandom));
      end else if (shape < 18) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WIDEST_INT) : $urandom_range(1, 8);
         len = $urandom_range(1, 64);
         case ($urandom_range(0, 19))
            0: len = 32'd0;
            1, 2: len = $urandom;
            default: ;
         endcase
         payload_bytes.push_back({1'b0, 1'($urandom), 6'(w - 1)});
         for (int k = 3; k >= 0; k--) payload_bytes.push_back(len[8*k +: 8]);
         lim = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
         covered = 0;
         while (covered < longint'(len) && bitq.size() < 96) begin
            v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 7));
            v &= lim;
            if (v >= 64'(longint'(len) - covered)) covered = longint'(len);
            else covered += longint'(v) + 1;
            for (int k = w - 1; k >= 0; k--) bitq.push_back(v[k]);
         end
         while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom));
         for (int i = 0; i < bitq.size(); i += 8) begin
            for (int k = 0; k < 8; k++) by[7 - k] = bitq[i + k];
            payload_bytes.push_back(by);
         end
         case ($urandom_range(0, 7))
            0: if (payload_bytes.size() > HEADER_BYTES) void'(payload_bytes.pop_back());
            1: repeat ($urandom_range(1, 2)) payload_bytes.push_back(8'($urandom));
            default: ;
         endcase
      end else begin
         repeat ($urandom_range(1, 9)) payload_bytes.push_back(8'($urandom));
      end
   endfunction

   task automatic send_beat(req_beat_type beat, bit fixed, bit one_run, rsp_beat_type fixed_rsp);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(beat);
      if (fixed) begin
         if (one_run) expected_runs.push_back(fixed_rsp);
      end else begin
         foreach (byte_runs[j]) expected_runs.push_back(byte_runs[j]);
      end
      if (!byte_ignored) useful_beats++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic report_field(string name, longint unsigned want, longint unsigned got);
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: run with none expected, expected nothing, got value %0d length %0h status %0d",
                     $time, rsp_data.bit_value, rsp_data.run_length, rsp_data.status);
            mismatches++;
         end else begin
            want_run = expected_runs.pop_front();
            runs_checked++;
            if (want_run.status != STATUS_OK) error_reports++;
            if (rsp_data.bit_value !== want_run.bit_value)
               report_field("bit_value", want_run.bit_value, rsp_data.bit_value);
            if (rsp_data.run_length !== want_run.run_length)
               report_field("run_length", want_run.run_length, rsp_data.run_length);
            if (rsp_data.last_run !== want_run.last_run)
               report_field("last_run", want_run.last_run, rsp_data.last_run);
            if (rsp_data.status !== want_run.status)
               report_field("status", want_run.status, rsp_data.status);
         end
      end
   end

   initial begin
      stall_style_type stall_style;
      int unsigned     style_left;
      int unsigned     tick;
      stall_style = STALL_NONE;
      style_left  = 0;
      tick        = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            if (style_left == 0) begin
               stall_style = stall_style_type'($urandom_range(0, 3));
               style_left  = $urandom_range(20, 200);
            end
            style_left--;
            tick++;
            case (stall_style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 70);
               STALL_PERIODIC: rsp_stall <= ((tick % 5) >= 3);
               default:        rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   initial begin
      req_beat_type beat;
      int unsigned  random_start;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      parse      = PARSE_HEADER;
      hdr_seen   = 0;
      is_bitmask = 1'b0;
      word_width = 1;
      first_value = 1'b0;
      mask_len   = '0;
      bits_out   = '0;
      shift_acc  = '0;
      shift_cnt  = 0;
      run_value  = 1'b0;
      body_bytes = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < OPENING_COUNT; i++) begin
         beat.data_byte = OPENING_ROWS[i].data_byte;
         beat.last_byte = OPENING_ROWS[i].last_byte;
         send_beat(beat, OPENING_ROWS[i].fixed, OPENING_ROWS[i].one_run,
                   OPENING_ROWS[i].fixed_rsp);
      end
      wait_for_drain();

      random_start = useful_beats;
      while (useful_beats - random_start < RANDOM_BEATS) begin
         build_payload();
         steady = (payloads % 9 == 4) || (payloads >= 6 && payloads < 9);
         if (payloads == 6) hold_asks++;
         if (payloads % 12 == 11) wait_for_drain();
         for (int i = 0; i < payload_bytes.size(); i++) begin
            beat.data_byte = payload_bytes[i];
            beat.last_byte = (i == payload_bytes.size() - 1);
            send_beat(beat, 1'b0, 1'b0, NO_RSP);
         end
         payloads++;
      end

      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d random payloads after %0d directed beats, %0d beats in all.",
               payloads, OPENING_COUNT, useful_beats);
      $display("Checked %0d runs, %0d of them status reports.", runs_checked, error_reports);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d runs outstanding.", expected_runs.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mprld_pkg.sv
hdl/mprld_front.sv
hdl/mprld_queue.sv
hdl/mprld_back.sv
hdl/mask_payload_run_length_decoder.sv
dv/tb_mask_payload_run_length_decoder.sv
